[design/lcgja_pkg.sv]
// shared constants and types for the jump-ahead lcg generator
package lcgja_pkg;

  localparam int unsigned StateW = 32;
  localparam int unsigned CountW = 31;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned RandW  = 15;
  localparam int unsigned RandLsb = 16;

  localparam logic [StateW-1:0] LcgMul    = 32'd214013;
  localparam logic [StateW-1:0] LcgInc    = 32'd2531011;
  localparam logic [StateW-1:0] LcgMulInv = 32'd3115528533;

  // item modes
  typedef enum logic [ModeW-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_ADVANCE = 2'd1,
    MODE_REVERSE = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  // result handoff from sequencer to output register
  typedef struct packed {
    logic              valid;
    logic [StateW-1:0] state;
  } res_t;

endpackage

[design/lcgja_mad.sv]
// shared 32-bit multiply-add unit, low half of a*b plus c
module lcgja_mad
  import lcgja_pkg::*;
(
  input  logic [StateW-1:0] a,
  input  logic [StateW-1:0] b,
  input  logic [StateW-1:0] c,
  output logic [StateW-1:0] q
);

  logic [2*StateW-1:0] prod;

  // full product, only the low half is kept
  assign prod = {{StateW{1'b0}}, a} * {{StateW{1'b0}}, b};
  assign q    = prod[StateW-1:0] + c;

endmodule

[design/lcgja_ctrl.sv]
// sequencer and working registers for load, jump-ahead and step back
module lcgja_ctrl
  import lcgja_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mode_t             in_mode,
  input  logic [StateW-1:0] in_seed,
  input  logic [CountW-1:0] in_count,
  output res_t              res,
  input  logic              res_take
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ACCM  = 8'b0000_0010,
    S_ACCI  = 8'b0000_0100,
    S_STPI  = 8'b0000_1000,
    S_STPM  = 8'b0001_0000,
    S_FINAL = 8'b0010_0000,
    S_REV   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t            state, state_next;
  logic [StateW-1:0] gstate;
  logic [StateW-1:0] step_mul;
  logic [StateW-1:0] step_inc;
  logic [StateW-1:0] acc_mul;
  logic [StateW-1:0] acc_inc;
  logic [CountW-1:0] count;
  logic [CountW-1:0] count_shr;
  logic [StateW-1:0] mad_a, mad_b, mad_c, mad_q;
  logic              accept;

  // pick the first op for the remaining count bits
  function automatic state_t first_op(input logic [CountW-1:0] cnt);
    state_t s;
    if (cnt == '0) begin
      s = S_FINAL;
    end else if (cnt[0]) begin
      s = S_ACCM;
    end else begin
      s = S_STPI;
    end
    return s;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign count_shr = {1'b0, count[CountW-1:1]};

  // operand selection for the shared unit
  always_comb begin
    mad_a = gstate;
    mad_b = acc_mul;
    mad_c = acc_inc;
    unique case (state)
      S_ACCM: begin
        mad_a = acc_mul;
        mad_b = step_mul;
        mad_c = '0;
      end
      S_ACCI: begin
        mad_a = acc_inc;
        mad_b = step_mul;
        mad_c = step_inc;
      end
      S_STPI: begin
        mad_a = step_inc;
        mad_b = step_mul;
        mad_c = step_inc;
      end
      S_STPM: begin
        mad_a = step_mul;
        mad_b = step_mul;
        mad_c = '0;
      end
      S_REV: begin
        mad_a = gstate - LcgInc;
        mad_b = LcgMulInv;
        mad_c = '0;
      end
      default: begin
        mad_a = gstate;
        mad_b = acc_mul;
        mad_c = acc_inc;
      end
    endcase
  end

  lcgja_mad u_mad (
    .a (mad_a),
    .b (mad_b),
    .c (mad_c),
    .q (mad_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_ADVANCE: state_next = first_op(in_count);
            MODE_REVERSE: state_next = S_REV;
            default:      state_next = S_IDLE;
          endcase
        end
      end
      S_ACCM:  state_next = S_ACCI;
      S_ACCI:  state_next = (count_shr == '0) ? S_FINAL : S_STPI;
      S_STPI:  state_next = S_STPM;
      S_STPM:  state_next = first_op(count_shr);
      S_FINAL: state_next = S_DONE;
      S_REV:   state_next = S_IDLE;
      S_DONE:  state_next = res_take ? S_IDLE : S_DONE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // generator state, reset to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      gstate <= '0;
    end else if (accept && in_mode == MODE_LOAD) begin
      gstate <= in_seed;
    end else if (state == S_FINAL || state == S_REV) begin
      gstate <= mad_q;
    end
  end

  // jump parameter registers
  always_ff @(posedge clk) begin
    if (accept) begin
      step_mul <= LcgMul;
      step_inc <= LcgInc;
      acc_mul  <= 32'd1;
      acc_inc  <= '0;
      count    <= in_count;
    end else begin
      unique case (state)
        S_ACCM: acc_mul <= mad_q;
        S_ACCI: acc_inc <= mad_q;
        S_STPI: step_inc <= mad_q;
        S_STPM: begin
          step_mul <= mad_q;
          count    <= count_shr;
        end
        default: ;
      endcase
    end
  end

  assign res.valid = (state == S_DONE);
  assign res.state = gstate;

endmodule

[design/lcg_jump_ahead_rng.sv]
// top level of the jump-ahead lcg generator with output register
//
//  channel | dir | tdata                                   | tuser
//  s_*     | in  | seed_value[31:0], jump_count[62:32]     | mode[1:0]
//  m_*     | out | random_value[14:0], state_after[46:15]  | -
//
// load and the unused mode keep the input open; step back closes it while the
// multiply-add unit runs.
// advance closes the input while it folds in the step per set count bit and squares it
// per bit below the top set bit, all on the single shared 32x32 multiply-add unit.
// the output register lets the next item in while a result waits;
// a finished advance holds only while that register is full and stalled.
// reset (rst, synchronous) clears the generator state to zero.
module lcg_jump_ahead_rng
  import lcgja_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // seed_value[31:0], jump_count[62:32], zero pad
  input  logic [1:0]  s_tuser,   // mode[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // random_value[14:0], state_after[46:15], zero pad
);

  res_t              res;
  logic              res_take;
  logic [StateW-1:0] out_state;
  mode_t             in_mode;

  assign in_mode = mode_t'(s_tuser);

  lcgja_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_mode  (in_mode),
    .in_seed  (s_tdata[StateW-1:0]),
    .in_count (s_tdata[StateW+CountW-1:StateW]),
    .res      (res),
    .res_take (res_take)
  );

  assign res_take = !m_tvalid || m_tready;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res.valid) begin
      out_state <= res.state;
    end
  end

  assign m_tdata = {1'b0, out_state, out_state[RandLsb+RandW-1:RandLsb]};

`ifndef SYNTHESIS
  // an advance keeps the input closed on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == MODE_ADVANCE) |=> !s_tready)
    else $error("input reopened right after an advance beat");

  // a new result only comes from a finished advance
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(res.valid))
    else $error("result without a finished advance");

  // random value matches state bits 30..16
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[14:0] == m_tdata[45:31]))
    else $error("random value does not match state");

  // load and step back never produce a result
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == MODE_LOAD || s_tuser == MODE_REVERSE))
      |=> !res.valid)
    else $error("result after load or step back");
`endif

endmodule
